// ----- hw/rtl/i2cse_pkg.sv -----
package i2cse_pkg;

  // Bus event codes, densely renumbered from the bus status
  typedef enum logic [3:0] {
    FnAddrWrite = 4'd0,
    FnDataAck   = 4'd1,
    FnDataNack  = 4'd2,
    FnStop      = 4'd3,
    FnAddrRead  = 4'd4,
    FnSentAck   = 4'd5,
    FnSentNack  = 4'd6,
    FnNoInfo    = 4'd7,
    FnBusErr    = 4'd8,
    FnOther     = 4'd9
  } func_e;

  // Action requested from the bus side
  typedef enum logic [2:0] {
    ActNone    = 3'd0,
    ActAck     = 3'd1,
    ActNack    = 3'd2,
    ActRelease = 3'd3,
    ActStop    = 3'd4
  } action_e;

  // Widths of the fixed payload fields
  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 32;
  localparam int unsigned FuncW  = 4;

  // One result item
  typedef struct packed {
    action_e          bus_action;
    logic             tx_load;
    logic [ByteW-1:0] tx_byte;
    logic             message_valid;
    logic [WordW-1:0] message_word;
    logic             busy;
  } result_t;

endpackage

// ----- hw/rtl/i2cse_core.sv -----
module i2cse_core import i2cse_pkg::*; #(
  parameter int unsigned MSG_BYTES = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [FuncW-1:0] func_i,
  input  logic [ByteW-1:0] rx_byte_i,
  input  logic             reply_valid_i,
  input  logic [WordW-1:0] reply_word_i,
  output result_t          result_o
);

  localparam int unsigned CntW = $clog2(MSG_BYTES + 1);
  localparam int unsigned IdxW = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
  localparam logic [CntW-1:0] Full = CntW'(MSG_BYTES);

  logic [ByteW-1:0] rx_buf_q [MSG_BYTES];
  logic [ByteW-1:0] tx_buf_q [MSG_BYTES];
  logic [ByteW-1:0] tx_buf_d [MSG_BYTES];
  logic [CntW-1:0]  rx_count_q, rx_count_d;
  logic [CntW-1:0]  tx_pos_q, tx_pos_d;
  logic [CntW-1:0]  tx_pos_eff;
  logic             busy_q, busy_d;
  logic             rx_wr;
  logic             reload;
  logic [2*WordW-1:0] reply_ext;
  logic [2*WordW-1:0] msg_ext;
  result_t          res;

  assign reply_ext = {{WordW{1'b0}}, reply_word_i};

  // Event decode and next state
  always_comb begin
    rx_count_d = rx_count_q;
    tx_pos_d   = tx_pos_q;
    busy_d     = busy_q;
    tx_buf_d   = tx_buf_q;
    rx_wr      = 1'b0;
    reload     = 1'b0;
    tx_pos_eff = tx_pos_q;
    msg_ext    = '0;
    res        = '0;
    res.bus_action = ActNone;

    unique case (func_e'(func_i))
      FnAddrWrite: begin
        busy_d         = 1'b1;
        rx_count_d     = '0;
        res.bus_action = ActAck;
      end
      FnDataAck: begin
        if (rx_count_q < Full) begin
          rx_wr      = 1'b1;
          rx_count_d = rx_count_q + CntW'(1);
        end
        res.bus_action = (rx_count_d < Full) ? ActAck : ActNack;
      end
      FnDataNack: begin
        res.bus_action = ActRelease;
      end
      FnStop: begin
        if (rx_count_q == Full) begin
          res.message_valid = 1'b1;
          for (int unsigned i = 0; i < MSG_BYTES; i++) begin
            if (i < 4) msg_ext[ByteW*i +: ByteW] = rx_buf_q[i];
          end
        end
        res.message_word = msg_ext[WordW-1:0];
        busy_d           = 1'b0;
        res.bus_action   = ActRelease;
      end
      FnAddrRead, FnSentAck: begin
        // a fresh reply on address + read restarts from its first byte
        if (func_e'(func_i) == FnAddrRead) begin
          busy_d = 1'b1;
          reload = reply_valid_i;
        end
        if (reload) begin
          for (int unsigned i = 0; i < MSG_BYTES; i++) begin
            tx_buf_d[i] = (i < 4) ? reply_ext[ByteW*i +: ByteW] : '0;
          end
          tx_pos_eff = '0;
        end
        res.tx_load = 1'b1;
        if (tx_pos_eff < Full) begin
          res.tx_byte = reload ? reply_ext[ByteW-1:0] : tx_buf_q[tx_pos_q[IdxW-1:0]];
          tx_pos_d    = tx_pos_eff + CntW'(1);
        end else begin
          res.tx_byte = '0;
          tx_pos_d    = tx_pos_eff;
        end
        res.bus_action = ActAck;
      end
      FnSentNack: begin
        busy_d         = 1'b0;
        res.tx_load    = 1'b1;
        res.bus_action = ActAck;
      end
      FnBusErr: begin
        res.bus_action = ActStop;
      end
      default: begin
      end
    endcase

    res.busy = busy_d;
  end

  assign result_o = res;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_count_q <= '0;
      tx_pos_q   <= '0;
      busy_q     <= 1'b0;
      for (int unsigned i = 0; i < MSG_BYTES; i++) tx_buf_q[i] <= '0;
    end else if (step_i) begin
      rx_count_q <= rx_count_d;
      tx_pos_q   <= tx_pos_d;
      busy_q     <= busy_d;
      tx_buf_q   <= tx_buf_d;
    end
  end

  // Receive bytes, no reset needed
  always_ff @(posedge clk_i) begin
    if (step_i && rx_wr) begin
      rx_buf_q[rx_count_q[IdxW-1:0]] <= rx_byte_i;
    end
  end

endmodule

// ----- hw/rtl/i2c_slave_event_handler.sv -----
// Two-wire bus slave event handler. Each input item is one bus event with the
// received byte and the application's reply; each yields exactly one result
// item with the bus action, an optional byte to transmit, an optional
// MSG_BYTES-byte message (first four bytes shown) and the busy state. An item
// is registered on entry, handled against the transfer state and registered
// on exit, so a result is valid once it has passed the input and result
// registers. One item can be taken every cycle while the output does not
// stall; output stalls hold the pipeline without loss.
module i2c_slave_event_handler import i2cse_pkg::*; #(
  parameter int unsigned MSG_BYTES = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [FuncW-1:0] func_i,
  input  logic [ByteW-1:0] rx_byte_i,
  input  logic             reply_valid_i,
  input  logic [WordW-1:0] reply_word_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [2:0]       bus_action_o,
  output logic             tx_load_o,
  output logic [ByteW-1:0] tx_byte_o,
  output logic             message_valid_o,
  output logic [WordW-1:0] message_word_o,
  output logic             busy_res_o
);

  logic             in_valid_q;
  logic [FuncW-1:0] func_q;
  logic [ByteW-1:0] rx_byte_q;
  logic             reply_valid_q;
  logic [WordW-1:0] reply_word_q;
  logic             out_valid_q;
  result_t          res_q;
  result_t          core_res;
  logic             out_adv;
  logic             step;

  // Pipeline flow control
  assign out_adv    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || out_adv;
  assign step       = in_valid_q && out_adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      func_q        <= func_i;
      rx_byte_q     <= rx_byte_i;
      reply_valid_q <= reply_valid_i;
      reply_word_q  <= reply_word_i;
    end
  end

  i2cse_core #(
    .MSG_BYTES(MSG_BYTES)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .func_i       (func_q),
    .rx_byte_i    (rx_byte_q),
    .reply_valid_i(reply_valid_q),
    .reply_word_i (reply_word_q),
    .result_o     (core_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= core_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign bus_action_o    = res_q.bus_action;
  assign tx_load_o       = res_q.tx_load;
  assign tx_byte_o       = res_q.tx_byte;
  assign message_valid_o = res_q.message_valid;
  assign message_word_o  = res_q.message_word;
  assign busy_res_o      = res_q.busy;

`ifndef SYNTHESIS
  // addressed for write always reports busy in its result
  a_addr_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && func_q == FnAddrWrite |=> out_valid_o && busy_res_o)
    else $error("address write result not busy");

  // a delivered message comes only with a release
  a_msg_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_valid_o |-> bus_action_o == ActRelease)
    else $error("message delivered without release");

  // a transmitted byte always goes with an ack
  a_tx_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tx_load_o |-> bus_action_o == ActAck)
    else $error("tx byte without ack");

  // input stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");
`endif

endmodule

// ----- test/i2c_slave_event_handler_test.sv -----
`timescale 1ns / 1ps

module i2c_slave_event_handler_test;
  import i2cse_pkg::*;

  localparam int unsigned MsgBytes = 4;

  // One bus event; a drain entry makes the sender wait for all answers
  typedef struct {
    logic             drain;
    logic [FuncW-1:0] func;
    logic [ByteW-1:0] rx_byte;
    logic             reply_valid;
    logic [WordW-1:0] reply_word;
  } bus_event_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [FuncW-1:0] func_i = '0;
  logic [ByteW-1:0] rx_byte_i = '0;
  logic             reply_valid_i = 1'b0;
  logic [WordW-1:0] reply_word_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [2:0]       bus_action_o;
  logic             tx_load_o;
  logic [ByteW-1:0] tx_byte_o;
  logic             message_valid_o;
  logic [WordW-1:0] message_word_o;
  logic             busy_res_o;

  i2c_slave_event_handler #(
    .MSG_BYTES(MsgBytes)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .rx_byte_i      (rx_byte_i),
    .reply_valid_i  (reply_valid_i),
    .reply_word_i   (reply_word_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .bus_action_o   (bus_action_o),
    .tx_load_o      (tx_load_o),
    .tx_byte_o      (tx_byte_o),
    .message_valid_o(message_valid_o),
    .message_word_o (message_word_o),
    .busy_res_o     (busy_res_o)
  );

  bus_event_t bus_events[$];
  result_t    expected_answers[$];
  int         n_events;
  int         n_sent = 0;
  int         n_err = 0;
  int         cyc = 0;
  int         hold_left = 0;
  logic       held_once = 1'b0;
  wire        calm = (cyc >= 600) && (cyc < 1100);

  // Shadow of the slave's transfer state
  logic [ByteW-1:0] rx_mem[MsgBytes];
  logic [ByteW-1:0] tx_mem[MsgBytes];
  int               rx_cnt;
  int               tx_pos;
  logic             busy_now;

  // Apply one event to the shadow state and return the answer it causes
  function automatic result_t handle_event(bus_event_t ev);
    result_t r;
    r = '0;
    case (ev.func)
      FnAddrWrite: begin
        busy_now = 1'b1;
        rx_cnt = 0;
        r.bus_action = ActAck;
      end
      FnDataAck: begin
        if (rx_cnt < MsgBytes) begin
          rx_mem[rx_cnt] = ev.rx_byte;
          rx_cnt++;
        end
        r.bus_action = (rx_cnt < MsgBytes) ? ActAck : ActNack;
      end
      FnDataNack: r.bus_action = ActRelease;
      FnStop: begin
        if (rx_cnt == MsgBytes) begin
          r.message_valid = 1'b1;
          for (int i = 0; i < MsgBytes && i < 4; i++) r.message_word[8*i +: 8] = rx_mem[i];
        end
        busy_now = 1'b0;
        r.bus_action = ActRelease;
      end
      FnAddrRead, FnSentAck: begin
        if (ev.func == FnAddrRead) begin
          busy_now = 1'b1;
          // a stale reply keeps buffer and position
          if (ev.reply_valid) begin
            for (int i = 0; i < MsgBytes; i++)
              tx_mem[i] = (i < 4) ? ev.reply_word[8*i +: 8] : '0;
            tx_pos = 0;
          end
        end
        r.tx_load = 1'b1;
        if (tx_pos < MsgBytes) begin
          r.tx_byte = tx_mem[tx_pos];
          tx_pos++;
        end
        r.bus_action = ActAck;
      end
      FnSentNack: begin
        busy_now = 1'b0;
        r.tx_load = 1'b1;
        r.bus_action = ActAck;
      end
      FnBusErr: r.bus_action = ActStop;
      default: ;
    endcase
    r.busy = busy_now;
    return r;
  endfunction

  // Queue one event; ignored codes do not count as stimulus
  task automatic push_event(logic [FuncW-1:0] f, logic [ByteW-1:0] b, logic v,
                            logic [WordW-1:0] w);
    bus_event_t ev;
    ev.drain = 1'b0;
    ev.func = f;
    ev.rx_byte = b;
    ev.reply_valid = v;
    ev.reply_word = w;
    bus_events.push_back(ev);
    if (f <= FnSentNack || f == FnBusErr) n_events++;
  endtask

  task automatic push_rand(logic [FuncW-1:0] f);
    logic [31:0] r;
    r = $urandom;
    push_event(f, r[7:0], r[8], $urandom);
  endtask

  task automatic push_drain();
    bus_event_t ev;
    ev = '{1'b1, '0, '0, 1'b0, '0};
    bus_events.push_back(ev);
  endtask

  // Clock and reset
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni) cyc <= cyc + 1;
  end

  // Driver: offers queued items, predicts each one as it is taken
  always @(posedge clk_i or negedge rst_ni) begin : drive
    bus_event_t cur;
    bus_event_t nxt;
    logic       take;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      rx_mem = '{default: '0};
      tx_mem = '{default: '0};
      rx_cnt = 0;
      tx_pos = 0;
      busy_now = 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        cur = '{1'b0, func_i, rx_byte_i, reply_valid_i, reply_word_i};
        expected_answers.push_back(handle_event(cur));
        n_sent <= n_sent + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        // a drain entry passes once every answer is back
        if (bus_events.size() != 0 && bus_events[0].drain && expected_answers.size() == 0)
          void'(bus_events.pop_front());
        take = bus_events.size() != 0 && !bus_events[0].drain &&
               (calm || $urandom_range(0, 99) >= 25);
        if (take) begin
          nxt = bus_events.pop_front();
          func_i <= nxt.func;
          rx_byte_i <= nxt.rx_byte;
          reply_valid_i <= nxt.reply_valid;
          reply_word_i <= nxt.reply_word;
        end
        in_valid_i <= take;
      end
    end
  end

  // Receiver ready: random stalls plus one long hold-off mid run
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!held_once && n_sent >= 800) begin
      held_once <= 1'b1;
      hold_left <= 300;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || $urandom_range(0, 99) >= 25;
    end
  end

  // Monitor: compare each answer with the oldest prediction
  always @(posedge clk_i) begin : check
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_answers.size() == 0) begin
        $error("unexpected answer: bus_action %0d tx_byte %0h", bus_action_o, tx_byte_o);
        n_err++;
      end else begin
        want = expected_answers.pop_front();
        if (want.bus_action != bus_action_o) begin
          $error("bus_action: expected %0d, got %0d", want.bus_action, bus_action_o);
          n_err++;
        end
        if (want.tx_load != tx_load_o) begin
          $error("tx_load: expected %0d, got %0d", want.tx_load, tx_load_o);
          n_err++;
        end
        if (want.tx_byte != tx_byte_o) begin
          $error("tx_byte: expected %02h, got %02h", want.tx_byte, tx_byte_o);
          n_err++;
        end
        if (want.message_valid != message_valid_o) begin
          $error("message_valid: expected %0d, got %0d", want.message_valid, message_valid_o);
          n_err++;
        end
        if (want.message_word != message_word_o) begin
          $error("message_word: expected %08h, got %08h", want.message_word, message_word_o);
          n_err++;
        end
        if (want.busy != busy_res_o) begin
          $error("busy_res: expected %0d, got %0d", want.busy, busy_res_o);
          n_err++;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int nb;
    n_events = 0;

    // stop and sent-ack straight after reset: nothing held, empty reply
    push_event(FnStop, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    push_event(FnSentAck, 8'h00, 1'b0, 32'h0000_0000);
    // full write transfer, extremes of the data byte, one byte too many
    push_event(FnAddrWrite, 8'h00, 1'b0, 32'h0);
    push_event(FnDataAck, 8'h00, 1'b0, 32'h0);
    push_event(FnDataAck, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    push_event(FnDataAck, 8'hA5, 1'b0, 32'h0);
    push_event(FnDataAck, 8'h5A, 1'b0, 32'h0);
    push_event(FnDataAck, 8'h3C, 1'b0, 32'h0);
    push_event(FnDataNack, 8'hFF, 1'b1, 32'h0);
    push_event(FnStop, 8'h00, 1'b0, 32'h0);
    // read: fresh reply, then a stale one continuing from the position
    push_event(FnAddrRead, 8'h00, 1'b1, 32'hFFFF_FFFF);
    push_event(FnSentAck, 8'h00, 1'b0, 32'h0);
    push_event(FnAddrRead, 8'hFF, 1'b0, 32'h0000_0000);
    push_event(FnSentAck, 8'h00, 1'b1, 32'h1234_5678);
    push_event(FnSentAck, 8'h00, 1'b0, 32'h0);
    // reply exhausted
    push_event(FnSentAck, 8'h00, 1'b0, 32'h0);
    push_event(FnAddrRead, 8'h00, 1'b1, 32'h8001_7F00);
    push_event(FnSentNack, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    // no-action codes and bus error
    push_event(FnNoInfo, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    push_event(FnBusErr, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    push_event(FnOther, 8'h00, 1'b0, 32'h0);
    push_event(4'hA, 8'h00, 1'b0, 32'h0);
    push_event(4'hF, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    // count still full: the message goes out again
    push_event(FnStop, 8'h00, 1'b0, 32'h0);
    push_drain();

    // random transfers with some noise
    while (n_events < 1500) begin
      if (n_events >= 1200 && n_events < 1210) push_drain();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          push_rand(FnAddrWrite);
          nb = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : MsgBytes;
          repeat (nb) push_rand(FnDataAck);
          if ($urandom_range(0, 9) == 0) push_rand(FnBusErr);
          if ($urandom_range(0, 1) == 0) push_rand(FnDataNack);
          if ($urandom_range(0, 9) != 0) push_rand(FnStop);
        end
        5, 6, 7: begin
          push_event(FnAddrRead, 8'($urandom), $urandom_range(0, 4) != 0, $urandom);
          repeat ($urandom_range(0, 6)) push_rand(FnSentAck);
          if ($urandom_range(0, 4) != 0) push_rand(FnSentNack);
          if ($urandom_range(0, 2) != 0) push_rand(FnStop);
        end
        default: begin
          repeat ($urandom_range(1, 4)) push_rand(4'($urandom_range(0, 15)));
        end
      endcase
    end

    wait (rst_ni);
    while (bus_events.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_answers.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (n_err == 0) begin
      $display("i2c_slave_event_handler verification clean");
    end else begin
      $display("i2c_slave_event_handler verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("i2c_slave_event_handler verification failed");
    $finish;
  end

endmodule
